@@ sv/rawtq_pkg.sv @@
package rawtq_pkg;

	localparam int FUNC_W    = 3;
	localparam int TASK_ID_W = 16;
	localparam int COUNT_W   = 5;

	localparam logic [FUNC_W-1:0] FN_ADD_RUN     = 3'd0;
	localparam logic [FUNC_W-1:0] FN_ADD_WAIT    = 3'd1;
	localparam logic [FUNC_W-1:0] FN_REMOVE_RUN  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_REMOVE_WAIT = 3'd3;
	localparam logic [FUNC_W-1:0] FN_WAIT_TO_RUN = 3'd4;
	localparam logic [FUNC_W-1:0] FN_RUN_TO_WAIT = 3'd5;

	// queue select bit, also the top bit of the memory address
	localparam logic Q_RUN  = 1'b0;
	localparam logic Q_WAIT = 1'b1;

	typedef struct packed {
		logic [FUNC_W-1:0]    func;
		logic [TASK_ID_W-1:0] task_id;
	} in_word_t;

	typedef struct packed {
		logic                 found;
		logic                 overflow;
		logic [TASK_ID_W-1:0] echo_id;
		logic [COUNT_W-1:0]   run_count;
		logic [COUNT_W-1:0]   wait_count;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_APPEND,
		ST_RESULT
	} rawtq_state_t;

endpackage

@@ sv/rawtq_stream_if.sv @@
interface rawtq_stream_if #(
	parameter type payload_t = logic [0:0]
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ sv/run_and_wait_task_queues.sv @@
// An append goes from accept through its write to the result; a remove or move
// reads and compares each entry scanned, reads and writes each later entry to
// shift it down, and a move then appends. One word in flight; a word takes longer
// the fuller its queue, set by the one-read-port entry memory and the one shared
// id comparator, plus output stalls. Reset clears both fill counts, the sequencer
// and the output valid flag; the output data and the entry memory are not cleared.
module run_and_wait_task_queues #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	rawtq_stream_if.sink   in_ch,
	rawtq_stream_if.source out_ch
);
	localparam int SW = (ID_BITS < 16) ? ID_BITS : 16;
	localparam int MW = $clog2(QUEUE_DEPTH) + 1;

	logic          mem_we;
	logic [MW-1:0] mem_waddr;
	logic [SW-1:0] mem_wdata;
	logic [MW-1:0] mem_raddr;
	logic [SW-1:0] mem_rdata;

	rawtq_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.ID_BITS    (ID_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	// run queue in the lower half, wait queue in the upper half
	rawtq_mem #(
		.DEPTH(2 * (2 ** (MW - 1))),
		.WIDTH(SW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);
endmodule

@@ sv/rawtq_mem.sv @@
module rawtq_mem #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ sv/rawtq_ctrl.sv @@
module rawtq_ctrl #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	rawtq_stream_if.sink                        in_ch,
	rawtq_stream_if.source                      out_ch,
	output logic                                mem_we,
	output logic [$clog2(QUEUE_DEPTH):0]        mem_waddr,
	output logic [((ID_BITS < 16) ? ID_BITS : 16)-1:0] mem_wdata,
	output logic [$clog2(QUEUE_DEPTH):0]        mem_raddr,
	input  logic [((ID_BITS < 16) ? ID_BITS : 16)-1:0] mem_rdata
);
	import rawtq_pkg::*;

	localparam int SW = (ID_BITS < 16) ? ID_BITS : 16;
	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	rawtq_state_t    state_q, state_d;
	logic [SW-1:0]   id_q;
	logic            src_q;
	logic            dst_q;
	logic            move_q;
	logic            found_q;
	logic            ovf_q;
	logic [CW-1:0]   idx_q;
	logic [CW-1:0]   fill_q [2];
	logic            out_valid_q;
	out_word_t       out_q;

	logic            in_src;
	logic            in_dst;
	logic [CW-1:0]   src_fill;
	logic [CW-1:0]   dst_fill;
	logic            dst_full;
	logic [CW-1:0]   idx_inc1;
	logic [CW-1:0]   idx_inc2;
	logic            hit;
	logic            more1;
	logic            more2;
	logic            out_free;
	rawtq_state_t    after_rm;

	assign in_src = (in_ch.data.func == FN_REMOVE_WAIT) || (in_ch.data.func == FN_WAIT_TO_RUN);
	assign in_dst = (in_ch.data.func == FN_ADD_WAIT) || (in_ch.data.func == FN_RUN_TO_WAIT);

	assign src_fill = fill_q[src_q];
	assign dst_fill = fill_q[dst_q];
	assign dst_full = (dst_fill == CW'(QUEUE_DEPTH));
	assign idx_inc1 = idx_q + CW'(1);
	assign idx_inc2 = idx_q + CW'(2);
	assign more1    = (idx_inc1 < src_fill);
	assign more2    = (idx_inc2 < src_fill);
	// the one comparator, reused for every entry of the scan
	assign hit      = (mem_rdata == id_q);
	assign out_free = !out_valid_q || out_ch.ready;
	assign after_rm = move_q ? ST_APPEND : ST_RESULT;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_ch.valid) begin
					case (in_ch.data.func) inside
						FN_ADD_RUN, FN_ADD_WAIT: state_d = ST_APPEND;
						FN_REMOVE_RUN, FN_REMOVE_WAIT, FN_WAIT_TO_RUN, FN_RUN_TO_WAIT: begin
							state_d = (fill_q[in_src] == '0) ? ST_RESULT : ST_SCAN_RD;
						end
						default: state_d = ST_RESULT;
					endcase
				end
			end
			ST_SCAN_RD:  state_d = ST_SCAN_CMP;
			ST_SCAN_CMP: begin
				if (hit) begin
					state_d = more1 ? ST_SHIFT_RD : after_rm;
				end else begin
					state_d = more1 ? ST_SCAN_RD : ST_RESULT;
				end
			end
			ST_SHIFT_RD: state_d = ST_SHIFT_WR;
			ST_SHIFT_WR: state_d = more2 ? ST_SHIFT_RD : after_rm;
			ST_APPEND:   state_d = ST_RESULT;
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready = (state_q == ST_IDLE);
		mem_we      = 1'b0;
		mem_waddr   = {src_q, idx_q[AW-1:0]};
		mem_wdata   = mem_rdata;
		mem_raddr   = {src_q, idx_q[AW-1:0]};
		unique case (state_q)
			ST_SHIFT_RD: mem_raddr = {src_q, idx_inc1[AW-1:0]};
			ST_SHIFT_WR: mem_we = 1'b1;
			ST_APPEND: begin
				mem_we    = !dst_full;
				mem_waddr = {dst_q, dst_fill[AW-1:0]};
				mem_wdata = id_q;
			end
			default: ;
		endcase
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q[0]   <= '0;
			fill_q[1]   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_RESULT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.valid && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						id_q    <= in_ch.data.task_id[SW-1:0];
						src_q   <= in_src;
						dst_q   <= in_dst;
						move_q  <= (in_ch.data.func == FN_WAIT_TO_RUN) ||
							(in_ch.data.func == FN_RUN_TO_WAIT);
						idx_q   <= '0;
						found_q <= 1'b0;
						ovf_q   <= 1'b0;
					end
				end
				ST_SCAN_CMP: begin
					if (hit) begin
						found_q <= 1'b1;
						if (!more1) begin
							fill_q[src_q] <= src_fill - CW'(1);
						end
					end else begin
						idx_q <= idx_inc1;
					end
				end
				ST_SHIFT_WR: begin
					idx_q <= idx_inc1;
					if (!more2) begin
						fill_q[src_q] <= src_fill - CW'(1);
					end
				end
				ST_APPEND: begin
					if (dst_full) begin
						ovf_q <= 1'b1;
					end else begin
						fill_q[dst_q] <= dst_fill + CW'(1);
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						out_q.found      <= found_q;
						out_q.overflow   <= ovf_q;
						out_q.echo_id    <= TASK_ID_W'(id_q);
						out_q.run_count  <= COUNT_W'(fill_q[Q_RUN]);
						out_q.wait_count <= COUNT_W'(fill_q[Q_WAIT]);
					end
				end
				default: ;
			endcase
		end
	end
endmodule

@@ sim/run_and_wait_task_queues_test.sv @@
`timescale 1ns / 1ps

module run_and_wait_task_queues_test;
	import rawtq_pkg::*;

	localparam int DEPTH = 16;
	localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
	localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;
	localparam int PHASE_COUNT  = 6;
	localparam int PHASE_WORDS  = 250;
	localparam int IDLE_LIMIT   = 5000;
	localparam int DRAIN_CYCLES = 100;
	localparam int ROW_COUNT    = 21;

	typedef struct packed {
		logic [FUNC_W-1:0]    func;
		logic [TASK_ID_W-1:0] task_id;
		logic                 typed;
		out_word_t            exp;
	} op_row_t;

	logic clk;
	logic arst_n;

	rawtq_stream_if #(.payload_t(in_word_t))  in_ch();
	rawtq_stream_if #(.payload_t(out_word_t)) out_ch();

	run_and_wait_task_queues #(
		.QUEUE_DEPTH(DEPTH),
		.ID_BITS    (TASK_ID_W)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch)
	);

	// mirror of both queues, indexed by Q_RUN / Q_WAIT
	logic [TASK_ID_W-1:0] queued_ids [2][$];
	out_word_t            pending_results[$];
	int                   fails = 0;
	int                   burst_left;
	int                   idle_cycles = 0;
	int                   stall_mode = 0;
	int                   stall_left = 0;

	// fixed rows first: empty-queue misses, spare selectors, duplicates, head/tail moves
	op_row_t op_rows [0:ROW_COUNT-1] = '{
		'{FN_REMOVE_RUN,  16'h0000, 1'b1, '{1'b0, 1'b0, 16'h0000, 5'd0, 5'd0}},
		'{FN_REMOVE_WAIT, 16'hFFFF, 1'b1, '{1'b0, 1'b0, 16'hFFFF, 5'd0, 5'd0}},
		'{FN_WAIT_TO_RUN, 16'h1234, 1'b1, '{1'b0, 1'b0, 16'h1234, 5'd0, 5'd0}},
		'{FN_RUN_TO_WAIT, 16'h8000, 1'b1, '{1'b0, 1'b0, 16'h8000, 5'd0, 5'd0}},
		'{FN_SPARE_6,     16'hFFFF, 1'b1, '{1'b0, 1'b0, 16'hFFFF, 5'd0, 5'd0}},
		'{FN_SPARE_7,     16'h0001, 1'b1, '{1'b0, 1'b0, 16'h0001, 5'd0, 5'd0}},
		'{FN_ADD_RUN,     16'h0000, 1'b1, '{1'b0, 1'b0, 16'h0000, 5'd1, 5'd0}},
		'{FN_ADD_RUN,     16'hFFFF, 1'b0, '0},
		'{FN_ADD_RUN,     16'h0000, 1'b0, '0},
		'{FN_ADD_WAIT,    16'hA5A5, 1'b0, '0},
		'{FN_ADD_WAIT,    16'h5A5A, 1'b0, '0},
		'{FN_REMOVE_RUN,  16'h0000, 1'b0, '0},
		'{FN_REMOVE_RUN,  16'h0000, 1'b0, '0},
		'{FN_REMOVE_RUN,  16'h0000, 1'b0, '0},
		'{FN_WAIT_TO_RUN, 16'h5A5A, 1'b0, '0},
		'{FN_WAIT_TO_RUN, 16'hA5A5, 1'b0, '0},
		'{FN_RUN_TO_WAIT, 16'hFFFF, 1'b0, '0},
		'{FN_REMOVE_WAIT, 16'hFFFF, 1'b0, '0},
		'{FN_SPARE_6,     16'h0000, 1'b0, '0},
		'{FN_REMOVE_RUN,  16'h5A5A, 1'b0, '0},
		'{FN_REMOVE_RUN,  16'hA5A5, 1'b0, '0}
	};

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic bit drop_id(logic sel, logic [TASK_ID_W-1:0] id);
		for (int i = 0; i < queued_ids[sel].size(); i++) begin
			if (queued_ids[sel][i] == id) begin
				queued_ids[sel].delete(i);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic bit append_id(logic sel, logic [TASK_ID_W-1:0] id);
		if (queued_ids[sel].size() >= DEPTH)
			return 1'b0;
		queued_ids[sel].push_back(id);
		return 1'b1;
	endfunction

	function automatic out_word_t apply_queue_op(in_word_t w);
		out_word_t r;
		r = '0;
		r.echo_id = w.task_id;
		case (w.func)
			FN_ADD_RUN:     r.overflow = !append_id(Q_RUN, w.task_id);
			FN_ADD_WAIT:    r.overflow = !append_id(Q_WAIT, w.task_id);
			FN_REMOVE_RUN:  r.found = drop_id(Q_RUN, w.task_id);
			FN_REMOVE_WAIT: r.found = drop_id(Q_WAIT, w.task_id);
			FN_WAIT_TO_RUN: begin
				r.found = drop_id(Q_WAIT, w.task_id);
				if (r.found)
					r.overflow = !append_id(Q_RUN, w.task_id);
			end
			FN_RUN_TO_WAIT: begin
				r.found = drop_id(Q_RUN, w.task_id);
				if (r.found)
					r.overflow = !append_id(Q_WAIT, w.task_id);
			end
			default: ;
		endcase
		r.run_count  = COUNT_W'(queued_ids[Q_RUN].size());
		r.wait_count = COUNT_W'(queued_ids[Q_WAIT].size());
		return r;
	endfunction

	// mostly ids already queued, some from a tiny pool (duplicates), rest anything
	function automatic logic [TASK_ID_W-1:0] pick_task_id();
		int  r;
		logic sel;
		r   = $urandom_range(0, 99);
		sel = logic'($urandom_range(0, 1));
		if (queued_ids[sel].size() == 0)
			sel = !sel;
		if (r < 60 && queued_ids[sel].size() != 0)
			return queued_ids[sel][$urandom_range(0, queued_ids[sel].size() - 1)];
		if (r < 80)
			return TASK_ID_W'($urandom_range(0, 7));
		return TASK_ID_W'($urandom);
	endfunction

	task automatic send_word(logic [FUNC_W-1:0] func, logic [TASK_ID_W-1:0] id,
			logic typed, out_word_t typed_exp);
		in_word_t  w;
		out_word_t predicted;
		if (burst_left == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		w.func    = func;
		w.task_id = id;
		in_ch.valid <= 1'b1;
		in_ch.data  <= w;
		do @(posedge clk); while (!in_ch.ready);
		predicted = apply_queue_op(w);
		pending_results.push_back(typed ? typed_exp : predicted);
		burst_left--;
	endtask

	task automatic wait_until_drained();
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(string name, logic [TASK_ID_W-1:0] exp_v,
			logic [TASK_ID_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, act_v);
			fails++;
		end
	endtask

	always @(posedge clk) begin : check_results
		out_word_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result word %p", $time, out_ch.data);
				fails++;
			end else begin
				want = pending_results.pop_front();
				check_field("found", TASK_ID_W'(want.found),
					TASK_ID_W'(out_ch.data.found));
				check_field("overflow", TASK_ID_W'(want.overflow),
					TASK_ID_W'(out_ch.data.overflow));
				check_field("echo_id", want.echo_id, out_ch.data.echo_id);
				check_field("run_count", TASK_ID_W'(want.run_count),
					TASK_ID_W'(out_ch.data.run_count));
				check_field("wait_count", TASK_ID_W'(want.wait_count),
					TASK_ID_W'(out_ch.data.wait_count));
			end
		end
	end

	// receiver: stretches of always-ready, coin-flip, and mostly-stalled
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(20, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0:       out_ch.ready <= 1'b1;
			1:       out_ch.ready <= 1'($urandom_range(0, 1));
			default: out_ch.ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("run_and_wait_task_queues test failed");
			$finish;
		end
	end

	initial begin
		int                   add_pct;
		int                   sent;
		int                   r;
		logic [FUNC_W-1:0]    func;
		logic [TASK_ID_W-1:0] id;
		arst_n       = 1'b0;
		in_ch.valid  = 1'b0;
		in_ch.data   = '0;
		burst_left   = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (op_rows[i])
			send_word(op_rows[i].func, op_rows[i].task_id, op_rows[i].typed, op_rows[i].exp);
		wait_until_drained();

		// cycle through fill-heavy, drain-heavy and mixed phases so both queues hit full and empty
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase % 3)
				0:       add_pct = 80;
				1:       add_pct = 15;
				default: add_pct = 45;
			endcase
			sent = 0;
			while (sent < PHASE_WORDS) begin
				r = $urandom_range(0, 99);
				if (r < 2)
					func = ($urandom_range(0, 1) != 0) ? FN_SPARE_7 : FN_SPARE_6;
				else if (r < 2 + add_pct)
					func = ($urandom_range(0, 1) != 0) ? FN_ADD_WAIT : FN_ADD_RUN;
				else
					func = FUNC_W'($urandom_range(FN_REMOVE_RUN, FN_RUN_TO_WAIT));
				id = pick_task_id();
				send_word(func, id, 1'b0, '0);
				if (func <= FN_RUN_TO_WAIT)
					sent++;
			end
			wait_until_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("run_and_wait_task_queues test passed");
		else
			$display("run_and_wait_task_queues test failed");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/rawtq_pkg.sv
sv/rawtq_stream_if.sv
sv/rawtq_mem.sv
sv/rawtq_ctrl.sv
sv/run_and_wait_task_queues.sv
sim/run_and_wait_task_queues_test.sv
